// ----- hw/rtl/tpwdq_pkg.sv -----
// ----------------------------------------------------------------------------
// tpwdq_pkg - timing protection watchdog queue package
// Shared defaults, operation and kind codes, and the queue control struct.
// ----------------------------------------------------------------------------
package tpwdq_pkg;

  localparam int PROC_COUNT_DEF     = 16;
  localparam int RESOURCE_SLOTS_DEF = 8;
  localparam int TIME_BITS_DEF      = 32;

  // operations
  localparam logic [2:0] OP_TICK     = 3'd0;
  localparam logic [2:0] OP_START    = 3'd1;
  localparam logic [2:0] OP_STOP     = 3'd2;
  localparam logic [2:0] OP_PAUSE    = 3'd3;
  localparam logic [2:0] OP_CONTINUE = 3'd4;

  // monitor kinds
  localparam logic [2:0] KIND_FRAME  = 3'd0;
  localparam logic [2:0] KIND_BUDGET = 3'd1;
  localparam logic [2:0] KIND_RES    = 3'd2;
  localparam logic [2:0] KIND_ALLINT = 3'd3;
  localparam logic [2:0] KIND_OSINT  = 3'd4;

  // event kinds
  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_FRAME  = 3'd1;
  localparam logic [2:0] EV_BUDGET = 3'd2;
  localparam logic [2:0] EV_RES    = 3'd3;
  localparam logic [2:0] EV_ALLINT = 3'd4;
  localparam logic [2:0] EV_OSINT  = 3'd5;

  // error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_TIME   = 2'd1;
  localparam logic [1:0] ERR_LOCKED = 2'd2;

  typedef struct packed {
    logic pop;   // drop head
    logic push;  // append at tail
  } q_ctrl_t;

endpackage

// ----- hw/rtl/tpwdq_queue.sv -----
// ----------------------------------------------------------------------------
// tpwdq_queue - watchdog entry queue
// Row of cells holding slot, deadline and owner; pop at head, push at tail.
// ----------------------------------------------------------------------------
module tpwdq_queue #(
  parameter int DEPTH     = 43,
  parameter int SLOT_W    = 6,
  parameter int TIME_BITS = tpwdq_pkg::TIME_BITS_DEF,
  parameter int LEN_W     = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tpwdq_pkg::q_ctrl_t   ctrl,
  input  logic [SLOT_W-1:0]    push_slot,
  input  logic [TIME_BITS-1:0] push_dl,
  input  logic [3:0]           push_owner,
  output logic [SLOT_W-1:0]    head_slot,
  output logic [TIME_BITS-1:0] head_dl,
  output logic [3:0]           head_owner,
  output logic [LEN_W-1:0]     len
);

  logic [SLOT_W-1:0]    slot  [DEPTH];
  logic [TIME_BITS-1:0] dl    [DEPTH];
  logic [3:0]           owner [DEPTH];

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (ctrl.pop) begin
        if (ctrl.push && (LEN_W'(i) == len - LEN_W'(1))) begin
          slot[i]  <= push_slot;
          dl[i]    <= push_dl;
          owner[i] <= push_owner;
        end else if (i < DEPTH - 1) begin
          slot[i]  <= slot[(i < DEPTH - 1) ? i + 1 : i];
          dl[i]    <= dl[(i < DEPTH - 1) ? i + 1 : i];
          owner[i] <= owner[(i < DEPTH - 1) ? i + 1 : i];
        end
      end else if (ctrl.push && (LEN_W'(i) == len)) begin
        slot[i]  <= push_slot;
        dl[i]    <= push_dl;
        owner[i] <= push_owner;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else begin
      len <= len + LEN_W'(ctrl.push) - LEN_W'(ctrl.pop);
    end
  end

  assign head_slot  = slot[0];
  assign head_dl    = dl[0];
  assign head_owner = owner[0];

endmodule

// ----- hw/rtl/timing_protection_watchdog_queue_core.sv -----
// ----------------------------------------------------------------------------
// timing_protection_watchdog_queue_core - timing protection watchdog queue
// Time base plus deadline-ordered watchdog queue walked by one comparator.
// ----------------------------------------------------------------------------
// Usage: pulse start with an item while busy is low. Each result shows on the
// result ports for exactly one cycle with strobe high; the receiver cannot
// stall, so capture every strobe. Start, stop, pause and continue for a valid
// monitored item rotate the whole queue once through a single deadline
// comparator and are then acknowledged; other items are only acknowledged.
// On a tick, expired slots stream out one per cycle, last marked on the final
// one. busy stays high until the last result is issued.
// ----------------------------------------------------------------------------
module timing_protection_watchdog_queue_core #(
  parameter int PROC_COUNT     = tpwdq_pkg::PROC_COUNT_DEF,
  parameter int RESOURCE_SLOTS = tpwdq_pkg::RESOURCE_SLOTS_DEF,
  parameter int TIME_BITS      = tpwdq_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation,
  input  logic [2:0]  monitor_kind,
  input  logic [3:0]  proc_id,
  input  logic [2:0]  resource_id,
  input  logic [31:0] limit_ticks,
  input  logic        monitored,
  output logic        strobe,
  output logic [2:0]  event_kind,
  output logic [3:0]  owner_proc,
  output logic [2:0]  owner_resource,
  output logic [1:0]  error_code,
  output logic        reschedule,
  output logic        may_activate,
  output logic        last
);

  localparam int NSLOTS  = 2 * PROC_COUNT + RESOURCE_SLOTS + 2;
  localparam int QDEPTH  = NSLOTS + 1;   // one spare: insert may precede removal
  localparam int SLOT_W  = $clog2(NSLOTS);
  localparam int LEN_W   = $clog2(QDEPTH + 1);
  localparam int PW      = (PROC_COUNT > 1) ? $clog2(PROC_COUNT) : 1;
  localparam int SW      = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
  localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};

  localparam logic [SLOT_W-1:0] SLOT_BUDGET0 = SLOT_W'(PROC_COUNT);
  localparam logic [SLOT_W-1:0] SLOT_RES0    = SLOT_W'(2 * PROC_COUNT);
  localparam logic [SLOT_W-1:0] SLOT_ALLINT  = SLOT_W'(2 * PROC_COUNT + RESOURCE_SLOTS);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PASS = 2'd1;
  localparam logic [1:0] S_EXP  = 2'd2;
  localparam logic [1:0] S_ACK  = 2'd3;

  logic [1:0]           state;
  logic [TIME_BITS-1:0] now;
  logic [PROC_COUNT-1:0] permit;
  logic [TIME_BITS-1:0] budget [PROC_COUNT];

  // latched item
  logic [3:0]           proc;
  logic [SLOT_W-1:0]    rm_slot;
  logic                 ins;
  logic                 cap;
  logic [TIME_BITS-1:0] new_dl;
  logic                 inserted;
  logic                 found;
  logic [TIME_BITS-1:0] cap_dl;
  logic [LEN_W-1:0]     cnt;
  logic [LEN_W-1:0]     len0;

  // pending expiry result
  logic       pend_v;
  logic [2:0] pend_ev;
  logic [3:0] pend_owner;
  logic [2:0] pend_res;
  logic [1:0] pend_err;
  logic       pend_act;
  logic       resched_acc;

  // queue
  tpwdq_pkg::q_ctrl_t   qc;
  logic [SLOT_W-1:0]    q_push_slot;
  logic [TIME_BITS-1:0] q_push_dl;
  logic [3:0]           q_push_owner;
  logic [SLOT_W-1:0]    head_slot;
  logic [TIME_BITS-1:0] head_dl;
  logic [3:0]           head_owner;
  logic [LEN_W-1:0]     q_len;

  tpwdq_queue #(
    .DEPTH(QDEPTH), .SLOT_W(SLOT_W), .TIME_BITS(TIME_BITS), .LEN_W(LEN_W)
  ) u_queue (
    .clk(clk), .rst(rst), .ctrl(qc),
    .push_slot(q_push_slot), .push_dl(q_push_dl), .push_owner(q_push_owner),
    .head_slot(head_slot), .head_dl(head_dl), .head_owner(head_owner), .len(q_len)
  );

  // the shared comparator: head deadline against key
  logic [TIME_BITS-1:0] cmp_key;
  logic                 head_gt;
  assign cmp_key = (state == S_PASS) ? new_dl : now;
  assign head_gt = head_dl > cmp_key;

  // item decode
  logic           proc_ok;
  logic [PW-1:0]  pidx;
  logic           slot_ok;
  logic [SLOT_W-1:0] sel_slot;
  logic [SW-1:0]  span;
  logic [SW-1:0]  dl_sum;
  logic [TIME_BITS-1:0] dl_calc;

  assign proc_ok = monitored && (5'(proc_id) < 5'(PROC_COUNT));
  assign pidx    = proc_id[PW-1:0];

  always_comb begin
    slot_ok  = 1'b0;
    sel_slot = '0;
    case (monitor_kind)
      tpwdq_pkg::KIND_FRAME: begin
        slot_ok  = 1'b1;
        sel_slot = SLOT_W'(proc_id);
      end
      tpwdq_pkg::KIND_BUDGET: begin
        slot_ok  = 1'b1;
        sel_slot = SLOT_BUDGET0 + SLOT_W'(proc_id);
      end
      tpwdq_pkg::KIND_RES: begin
        slot_ok  = (4'(resource_id) < 4'(RESOURCE_SLOTS)) && (limit_ticks != '0);
        sel_slot = SLOT_RES0 + SLOT_W'(resource_id);
      end
      tpwdq_pkg::KIND_ALLINT: begin
        slot_ok  = limit_ticks != '0;
        sel_slot = SLOT_ALLINT;
      end
      tpwdq_pkg::KIND_OSINT: begin
        slot_ok  = limit_ticks != '0;
        sel_slot = SLOT_ALLINT + SLOT_W'(1);
      end
      default: begin
        slot_ok  = 1'b0;
        sel_slot = '0;
      end
    endcase
  end

  // saturating deadline: now + span
  assign span    = (operation == tpwdq_pkg::OP_CONTINUE) ?
                   SW'(budget[pidx]) : SW'(limit_ticks);
  assign dl_sum  = SW'(now) + span;
  assign dl_calc = (dl_sum > SW'(TMAX)) ? TMAX : dl_sum[TIME_BITS-1:0];

  // expiry classification of the head slot
  logic [2:0] h_ev;
  logic [1:0] h_err;
  logic [2:0] h_res;
  always_comb begin
    h_res = '0;
    if (head_slot < SLOT_BUDGET0) begin
      h_ev = tpwdq_pkg::EV_FRAME;   h_err = tpwdq_pkg::ERR_NONE;
    end else if (head_slot < SLOT_RES0) begin
      h_ev = tpwdq_pkg::EV_BUDGET;  h_err = tpwdq_pkg::ERR_TIME;
    end else if (head_slot < SLOT_ALLINT) begin
      h_ev = tpwdq_pkg::EV_RES;     h_err = tpwdq_pkg::ERR_LOCKED;
      h_res = 3'(head_slot - SLOT_RES0);
    end else if (head_slot == SLOT_ALLINT) begin
      h_ev = tpwdq_pkg::EV_ALLINT;  h_err = tpwdq_pkg::ERR_LOCKED;
    end else begin
      h_ev = tpwdq_pkg::EV_OSINT;   h_err = tpwdq_pkg::ERR_LOCKED;
    end
  end

  logic h_owner_ok;
  logic proc_permit;
  assign h_owner_ok  = 5'(head_owner) < 5'(PROC_COUNT);
  assign proc_permit = (5'(proc) < 5'(PROC_COUNT)) ? permit[proc[PW-1:0]] : 1'b1;

  // queue control
  logic pass_run;
  logic pass_match;
  assign pass_run   = cnt < len0;
  assign pass_match = head_slot == rm_slot;

  always_comb begin
    qc           = '0;
    q_push_slot  = head_slot;
    q_push_dl    = head_dl;
    q_push_owner = head_owner;
    if (state == S_PASS) begin
      if (pass_run) begin
        if (pass_match) begin
          qc.pop = 1'b1;
        end else if (ins && !inserted && head_gt) begin
          qc.push      = 1'b1;
          q_push_slot  = rm_slot;
          q_push_dl    = new_dl;
          q_push_owner = proc;
        end else begin
          qc.pop  = 1'b1;
          qc.push = 1'b1;
        end
      end else if (ins && !inserted) begin
        qc.push      = 1'b1;
        q_push_slot  = rm_slot;
        q_push_dl    = new_dl;
        q_push_owner = proc;
      end
    end else if (state == S_EXP) begin
      qc.pop = (q_len != '0) && !head_gt;
    end
  end

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      now    <= '0;
      permit <= '1;
      strobe <= 1'b0;
      pend_v <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            proc     <= proc_id;
            inserted <= 1'b0;
            found    <= 1'b0;
            cnt      <= '0;
            len0     <= q_len;
            new_dl   <= dl_calc;
            ins      <= 1'b0;
            cap      <= 1'b0;
            rm_slot  <= sel_slot;
            state    <= S_ACK;
            if (operation == tpwdq_pkg::OP_TICK) begin
              if (now != TMAX) now <= now + TIME_BITS'(1);
              pend_v      <= 1'b0;
              resched_acc <= 1'b0;
              state       <= S_EXP;
            end else if (proc_ok) begin
              if ((operation == tpwdq_pkg::OP_START ||
                   operation == tpwdq_pkg::OP_STOP) && slot_ok) begin
                ins   <= operation == tpwdq_pkg::OP_START;
                state <= S_PASS;
                if (operation == tpwdq_pkg::OP_START &&
                    monitor_kind == tpwdq_pkg::KIND_FRAME)
                  permit[pidx] <= 1'b0;
              end else if (operation == tpwdq_pkg::OP_PAUSE) begin
                rm_slot <= SLOT_BUDGET0 + SLOT_W'(proc_id);
                cap     <= 1'b1;
                state   <= S_PASS;
              end else if (operation == tpwdq_pkg::OP_CONTINUE) begin
                rm_slot <= SLOT_BUDGET0 + SLOT_W'(proc_id);
                ins     <= 1'b1;
                state   <= S_PASS;
              end
            end
          end
        end
        S_PASS: begin
          if (pass_run) begin
            if (pass_match) begin
              found  <= 1'b1;
              cap_dl <= head_dl;
              cnt    <= cnt + LEN_W'(1);
            end else if (ins && !inserted && head_gt) begin
              inserted <= 1'b1;
            end else begin
              cnt <= cnt + LEN_W'(1);
            end
          end else begin
            if (cap && found)
              budget[proc[PW-1:0]] <= (cap_dl > now) ? cap_dl - now : '0;
            state <= S_ACK;
          end
        end
        S_EXP: begin
          if ((q_len != '0) && !head_gt) begin
            if (pend_v) begin
              strobe <= 1'b1;
              event_kind <= pend_ev; owner_proc <= pend_owner;
              owner_resource <= pend_res; error_code <= pend_err;
              may_activate <= pend_act; reschedule <= 1'b0; last <= 1'b0;
            end
            if (h_ev == tpwdq_pkg::EV_FRAME && h_owner_ok)
              permit[head_owner[PW-1:0]] <= 1'b1;
            if (h_ev == tpwdq_pkg::EV_BUDGET) resched_acc <= 1'b1;
            pend_v     <= 1'b1;
            pend_ev    <= h_ev;
            pend_owner <= head_owner;
            pend_res   <= h_res;
            pend_err   <= h_err;
            pend_act   <= !h_owner_ok || (h_ev == tpwdq_pkg::EV_FRAME) ||
                          permit[head_owner[PW-1:0]];
          end else begin
            strobe <= 1'b1;
            last   <= 1'b1;
            if (pend_v) begin
              event_kind <= pend_ev; owner_proc <= pend_owner;
              owner_resource <= pend_res; error_code <= pend_err;
              may_activate <= pend_act; reschedule <= resched_acc;
            end else begin
              event_kind <= tpwdq_pkg::EV_NONE; owner_proc <= '0;
              owner_resource <= '0; error_code <= tpwdq_pkg::ERR_NONE;
              may_activate <= permit[0]; reschedule <= 1'b0;
            end
            pend_v <= 1'b0;
            state  <= S_IDLE;
          end
        end
        S_ACK: begin
          strobe             <= 1'b1;
          event_kind         <= tpwdq_pkg::EV_NONE;
          owner_proc         <= proc;
          owner_resource     <= '0;
          error_code         <= tpwdq_pkg::ERR_NONE;
          reschedule         <= 1'b0;
          may_activate       <= proc_permit;
          last               <= 1'b1;
          state              <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // queue never holds more than one entry per slot between items
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (q_len <= LEN_W'(NSLOTS)))
    else $error("queue length beyond slot count");

  // results of one run come back to back until the last one
  a_run_contig: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe)
    else $error("gap inside expiry run");

  // an accepted item holds busy for at least the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // a final result always returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> (state == S_IDLE))
    else $error("last result while still busy");

endmodule
